// ----- sv/indexed_indirect_ea_unit_core_assert.svh -----
// Assertion macros shared by the effective-address unit RTL.
`ifndef INDEXED_INDIRECT_EA_UNIT_CORE_ASSERT_SVH
`define INDEXED_INDIRECT_EA_UNIT_CORE_ASSERT_SVH

// same-cycle implication, reset-qualified
`define IEEA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset-qualified
`define IEEA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/ieea_pkg.sv -----
// Types, constants and microcode ROM of the effective-address unit.
package ieea_pkg;

   localparam int ADDR_W    = 18;
   localparam int WORD_W    = 36;
   localparam int IDX_W     = 4;
   localparam int LIM_W     = 16;
   localparam int OP_W      = 2;
   localparam int ST_W      = 2;

   localparam int MEM_WORDS = 4096;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int AC_COUNT  = 16;
   localparam int AC_AW     = $clog2(AC_COUNT);

   // accumulators shadow the low 020 addresses
   localparam logic [ADDR_W-1:0] AC_SPACE = ADDR_W'(16);
   localparam logic [ADDR_W:0]   MEM_END  = (ADDR_W+1)'(MEM_WORDS);
   localparam logic [LIM_W-1:0]  LIMIT_RESET = LIM_W'(256);

   // indirect word layout
   localparam int IND_POS = 22;
   localparam int IDX_LSB = 18;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_EA    = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_LIMIT = 2'd2;

   // read address source
   localparam logic [1:0] RD_NONE = 2'd0;
   localparam logic [1:0] RD_ADDR = 2'd1;
   localparam logic [1:0] RD_IDX  = 2'd2;
   localparam logic [1:0] RD_YSUM = 2'd3;

   // early-exit check
   localparam logic [1:0] CHK_NONE = 2'd0;
   localparam logic [1:0] CHK_ADDR = 2'd1;
   localparam logic [1:0] CHK_EA   = 2'd2;

   localparam int UPC_W = 3;
   localparam logic [UPC_W-1:0] UPC_WR  = 3'd0;
   localparam logic [UPC_W-1:0] UPC_RA  = 3'd1;
   localparam logic [UPC_W-1:0] UPC_RB  = 3'd2;
   localparam logic [UPC_W-1:0] UPC_EA0 = 3'd3;
   localparam logic [UPC_W-1:0] UPC_EA1 = 3'd4;
   localparam logic [UPC_W-1:0] UPC_EA2 = 3'd5;
   localparam logic [UPC_W-1:0] UPC_NOP = 3'd6;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ADDR_W-1:0] address;
      logic [WORD_W-1:0] data;
      logic              ind_bit;
      logic [IDX_W-1:0]  index_reg;
      logic [ADDR_W-1:0] offset_y;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] eff_addr;
      logic [WORD_W-1:0] read_data;
      logic [ST_W-1:0]   status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       rd_src;
      logic             wr;
      logic [1:0]       chk;
      logic             cnt_inc;
      logic             take_rd;
      logic             load_ptr;
      logic             fin;
      logic [UPC_W-1:0] nxt;
   } ucode_type;

   typedef struct packed {
      logic      busy;
      logic      fin;
      logic      adv;
      ucode_type uc;
   } ctl_type;

   function automatic ucode_type ucode_rom(input logic [UPC_W-1:0] upc);
      ucode_type uc;
      uc = '0;
      unique case (upc)
         UPC_WR: begin
            uc.wr  = 1'b1;
            uc.chk = CHK_ADDR;
            uc.fin = 1'b1;
         end
         UPC_RA: begin
            uc.rd_src = RD_ADDR;
            uc.chk    = CHK_ADDR;
            uc.nxt    = UPC_RB;
         end
         UPC_RB: begin
            uc.take_rd = 1'b1;
            uc.fin     = 1'b1;
         end
         UPC_EA0: begin
            uc.rd_src = RD_IDX;
            uc.nxt    = UPC_EA1;
         end
         UPC_EA1: begin
            uc.rd_src  = RD_YSUM;
            uc.chk     = CHK_EA;
            uc.cnt_inc = 1'b1;
            uc.nxt     = UPC_EA2;
         end
         UPC_EA2: begin
            uc.load_ptr = 1'b1;
            uc.nxt      = UPC_EA0;
         end
         UPC_NOP: begin
            uc.fin = 1'b1;
         end
         default: begin
            uc.fin = 1'b1;
         end
      endcase
      return uc;
   endfunction

   // dispatch map: opcode to first step
   function automatic logic [UPC_W-1:0] entry_upc(input logic [OP_W-1:0] op);
      logic [UPC_W-1:0] upc;
      unique case (op)
         OP_WRITE: upc = UPC_WR;
         OP_READ:  upc = UPC_RA;
         OP_EA:    upc = UPC_EA0;
         OP_NONE:  upc = UPC_NOP;
         default:  upc = UPC_NOP;
      endcase
      return upc;
   endfunction

endpackage

// ----- sv/ieea_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ieea_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- sv/ieea_seq.sv -----
// Microcode sequencer: step counter, ROM lookup and dispatch.
module ieea_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [ieea_pkg::OP_W-1:0] opcode,
   input  logic                     stop,
   input  logic                     slot_free,
   output ieea_pkg::ctl_type        ctl
);
   import ieea_pkg::*;

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] pc_ff, pc_in;
   ucode_type        uc;
   logic             fin, adv, start;

   assign uc    = ucode_rom(pc_ff);
   assign fin   = busy_ff && (uc.fin || stop);
   // a finishing step waits until the result register can take it
   assign adv   = !fin || slot_free;
   assign start = req_valid && !busy_ff;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      priority if (start) begin
         busy_in = 1'b1;
         pc_in   = entry_upc(opcode);
      end else if (busy_ff && adv) begin
         if (fin) begin
            busy_in = 1'b0;
         end else begin
            pc_in = uc.nxt;
         end
      end else begin
         // idle, or a finishing step held by a full result register
         busy_in = busy_ff;
         pc_in   = pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= UPC_NOP;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign ctl.busy = busy_ff;
   assign ctl.fin  = fin;
   assign ctl.adv  = adv;
   assign ctl.uc   = uc;
endmodule

// ----- sv/ieea_dp.sv -----
// Datapath: accumulators, word memory, address adder and chain registers.
module ieea_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  ieea_pkg::req_type          req,
   input  ieea_pkg::ctl_type          ctl,
   input  logic                       csr_we,
   input  logic [ieea_pkg::LIM_W-1:0] csr_wdata,
   output logic                       stop,
   output ieea_pkg::rsp_type          result
);
   import ieea_pkg::*;

   logic [ADDR_W-1:0]   addr_ff;
   logic [WORD_W-1:0]   data_ff;
   logic                ind_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [ADDR_W-1:0]   y_ff;
   logic [LIM_W-1:0]    fetch_ff, fetch_in;
   logic [LIM_W-1:0]    limit_ff;
   logic                src_ac_ff;
   logic                ac_rvld_ff;
   logic [AC_COUNT-1:0] ac_vld_ff;

   logic [WORD_W-1:0] ac_q, mem_q, ac_word, word;
   logic [ADDR_W-1:0] add_term, ysum;
   logic              addr_ac, addr_oor, ysum_ac, ysum_oor, lim_hit;
   logic              go, ac_re, mem_re, rd_is_ac, ac_we, mem_we;
   logic [AC_AW-1:0]  ac_raddr;
   logic [MEM_AW-1:0] mem_raddr;
   logic [ST_W-1:0]   status;

   assign go = ctl.busy && ctl.adv;

   // never-written accumulators read as zero
   assign ac_word  = ac_rvld_ff ? ac_q : '0;
   assign word     = src_ac_ff ? ac_word : mem_q;
   assign add_term = (idx_ff != '0) ? ac_word[ADDR_W-1:0] : '0;
   assign ysum     = y_ff + add_term;

   assign addr_ac  = addr_ff < AC_SPACE;
   assign addr_oor = {1'b0, addr_ff} >= MEM_END;
   assign ysum_ac  = ysum < AC_SPACE;
   assign ysum_oor = {1'b0, ysum} >= MEM_END;
   assign lim_hit  = fetch_ff >= limit_ff;

   always_comb begin
      stop   = 1'b0;
      status = ST_OK;
      unique case (ctl.uc.chk)
         CHK_ADDR: begin
            stop   = addr_oor;
            status = addr_oor ? ST_RANGE : ST_OK;
         end
         CHK_EA: begin
            stop = !ind_ff || lim_hit || ysum_oor;
            priority if (!ind_ff) begin
               status = ST_OK;
            end else if (lim_hit) begin
               status = ST_LIMIT;
            end else begin
               status = ST_RANGE;
            end
         end
         default: begin
            stop   = 1'b0;
            status = ST_OK;
         end
      endcase
   end

   assign result.eff_addr  = (ctl.uc.chk == CHK_EA) ? ysum : '0;
   assign result.read_data = ctl.uc.take_rd ? word : '0;
   assign result.status    = status;

   always_comb begin
      ac_raddr  = addr_ff[AC_AW-1:0];
      mem_raddr = addr_ff[MEM_AW-1:0];
      ac_re     = 1'b0;
      mem_re    = 1'b0;
      rd_is_ac  = 1'b0;
      unique case (ctl.uc.rd_src)
         RD_ADDR: begin
            ac_re    = go;
            mem_re   = go;
            rd_is_ac = addr_ac;
         end
         RD_IDX: begin
            ac_raddr = idx_ff;
            ac_re    = go;
            rd_is_ac = 1'b1;
         end
         RD_YSUM: begin
            ac_raddr  = ysum[AC_AW-1:0];
            mem_raddr = ysum[MEM_AW-1:0];
            ac_re     = go;
            mem_re    = go;
            rd_is_ac  = ysum_ac;
         end
         default: begin
            ac_re  = 1'b0;
            mem_re = 1'b0;
         end
      endcase
   end

   assign ac_we  = go && ctl.uc.wr && addr_ac;
   assign mem_we = go && ctl.uc.wr && !addr_ac && !addr_oor;

   ieea_ram #(.WIDTH(WORD_W), .DEPTH(AC_COUNT)) u_ac (
      .clock (clock),
      .we    (ac_we),
      .waddr (addr_ff[AC_AW-1:0]),
      .wdata (data_ff),
      .re    (ac_re),
      .raddr (ac_raddr),
      .rdata (ac_q)
   );

   ieea_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (addr_ff[MEM_AW-1:0]),
      .wdata (data_ff),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_q)
   );

   always_comb begin
      fetch_in = fetch_ff;
      if (start) begin
         fetch_in = '0;
      end else if (go && ctl.uc.cnt_inc && !stop) begin
         fetch_in = fetch_ff + LIM_W'(1);
      end
   end

   // chain and request registers
   always_ff @(posedge clock) begin
      fetch_ff <= fetch_in;
      if (start) begin
         addr_ff <= req.address;
         data_ff <= req.data;
         ind_ff  <= req.ind_bit;
         idx_ff  <= req.index_reg;
         y_ff    <= req.offset_y;
      end else if (go && ctl.uc.load_ptr) begin
         ind_ff  <= word[IND_POS];
         idx_ff  <= word[IDX_LSB +: IDX_W];
         y_ff    <= word[ADDR_W-1:0];
      end
      if (ac_re) begin
         ac_rvld_ff <= ac_vld_ff[ac_raddr];
         src_ac_ff  <= rd_is_ac;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ac_vld_ff <= '0;
         limit_ff  <= LIMIT_RESET;
      end else begin
         if (ac_we) begin
            ac_vld_ff[addr_ff[AC_AW-1:0]] <= 1'b1;
         end
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end
endmodule

// ----- sv/indexed_indirect_ea_unit_core.sv -----
// Top level of the indexed/indirect effective-address unit.
`include "indexed_indirect_ea_unit_core_assert.svh"

// Word store plus 16 accumulators, with an effective-address walker. One request
// is worked at a time by a small microcoded sequencer; a new request is taken
// as soon as the previous one has left the sequencer, even while its response
// still waits in the output register. A write or an unused opcode finishes in
// its first step and a read in its data step, unless its address is out of
// range; an effective address repeats its steps for each indirect fetch. The
// sequencer frees as the response is loaded, so the next request is accepted in
// the cycle after at the earliest. A response register that is still full holds
// the finishing step until it drains. The step sequence is set by the registered
// read port of the accumulator file and the word memory: each level reads the
// index accumulator, adds and checks, then reads the pointed-to word. Accumulators
// read as zero until written (per-entry valid bits); the word memory has no clear
// and must be written before it is read. csr_wdata sets the indirection limit
// (reset 256); write it only while the unit is idle.
module indexed_indirect_ea_unit_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ieea_pkg::req_type          req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ieea_pkg::rsp_type          rsp_payload,
   input  logic                       csr_we,
   input  logic [ieea_pkg::LIM_W-1:0] csr_wdata
);
   import ieea_pkg::*;

   ctl_type ctl;
   rsp_type result;
   logic    stop, start, slot_free, load;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff;

   // output slot is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = !ctl.busy;
   assign start     = req_valid && req_ready;
   assign load      = ctl.fin && ctl.adv;

   ieea_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .opcode    (req_payload.opcode),
      .stop      (stop),
      .slot_free (slot_free),
      .ctl       (ctl)
   );

   ieea_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_payload),
      .ctl       (ctl),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .stop      (stop),
      .result    (result)
   );

   // response register
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `IEEA_ASSERT_NEXT(a_fin_loads_rsp, load, rsp_valid_ff, "finished step did not load response")
   `IEEA_ASSERT_NEXT(a_accept_busy, start, ctl.busy, "accepted request did not start sequencer")
   `IEEA_ASSERT_IMPL(a_read_excl, rsp_valid_ff && (rsp_payload_ff.read_data != '0),
      (rsp_payload_ff.eff_addr == '0) && (rsp_payload_ff.status == ST_OK),
      "read data alongside address or error")
   `IEEA_ASSERT_IMPL(a_fin_busy, ctl.fin, ctl.busy, "finish outside a request")
endmodule

// ----- tb/indexed_indirect_ea_unit_core_checker.sv -----
// Response checker for the effective-address unit: tracks state, predicts and compares.
module indexed_indirect_ea_unit_core_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  ieea_pkg::req_type          req_payload,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  ieea_pkg::rsp_type          rsp_payload,
   input  logic                       csr_we,
   input  logic [ieea_pkg::LIM_W-1:0] csr_wdata,
   output int unsigned                fault_total
);
   timeunit 1ns;
   timeprecision 1ps;
   import ieea_pkg::*;

   logic [WORD_W-1:0] ac_file    [AC_COUNT];
   logic [WORD_W-1:0] word_store [MEM_WORDS];
   logic [LIM_W-1:0]  walk_limit = LIMIT_RESET;
   rsp_type           queued_outcomes [$];
   int unsigned       mismatches = 0;

   // Applies one request to the local copy of the unit and returns its response.
   function automatic rsp_type run_request(input req_type r);
      rsp_type           o;
      logic              ind;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] y;
      logic [WORD_W-1:0] w;
      int unsigned       hops;
      bit                done;
      o = '0;
      case (r.opcode)
         OP_WRITE: begin
            if (r.address < AC_SPACE)
               ac_file[r.address[AC_AW-1:0]] = r.data;
            else if (r.address < MEM_END)
               word_store[r.address[MEM_AW-1:0]] = r.data;
            else
               o.status = ST_RANGE;
         end
         OP_READ: begin
            if (r.address < AC_SPACE)
               o.read_data = ac_file[r.address[AC_AW-1:0]];
            else if (r.address < MEM_END)
               o.read_data = word_store[r.address[MEM_AW-1:0]];
            else
               o.status = ST_RANGE;
         end
         OP_EA: begin
            ind  = r.ind_bit;
            idx  = r.index_reg;
            y    = r.offset_y;
            hops = 0;
            done = 1'b0;
            while (!done) begin
               // index add wraps at 18 bits
               if (idx != '0)
                  y = y + ac_file[idx][ADDR_W-1:0];
               if (!ind) begin
                  done = 1'b1;
               end else if (hops >= walk_limit) begin
                  o.status = ST_LIMIT;
                  done     = 1'b1;
               end else if (y >= MEM_END) begin
                  o.status = ST_RANGE;
                  done     = 1'b1;
               end else begin
                  hops++;
                  w   = (y < AC_SPACE) ? ac_file[y[AC_AW-1:0]] : word_store[y[MEM_AW-1:0]];
                  ind = w[IND_POS];
                  idx = w[IDX_LSB +: IDX_W];
                  y   = w[ADDR_W-1:0];
               end
            end
            o.eff_addr = y;
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         foreach (ac_file[i]) ac_file[i] = '0;
         walk_limit = LIMIT_RESET;
         queued_outcomes.delete();
      end else begin
         if (csr_we)
            walk_limit = csr_wdata;
         if (req_valid && req_ready)
            queued_outcomes.push_back(run_request(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (queued_outcomes.size() == 0) begin
               mismatches++;
               $error("response arrived with no request outstanding");
            end else begin
               want = queued_outcomes.pop_front();
               if (rsp_payload.eff_addr !== want.eff_addr) begin
                  mismatches++;
                  $error("eff_addr: expected %05h, got %05h", want.eff_addr,
                         rsp_payload.eff_addr);
               end
               if (rsp_payload.read_data !== want.read_data) begin
                  mismatches++;
                  $error("read_data: expected %09h, got %09h", want.read_data,
                         rsp_payload.read_data);
               end
               if (rsp_payload.status !== want.status) begin
                  mismatches++;
                  $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               end
            end
         end
      end
      // outstanding predictions count as faults once the run is over
      fault_total = mismatches + queued_outcomes.size();
   end

endmodule

// ----- tb/indexed_indirect_ea_unit_core_tb.sv -----
// Testbench top for the effective-address unit: stimulus, flow control and verdict.
module indexed_indirect_ea_unit_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ieea_pkg::*;

   // A walk is only sent if it ends within this many fetches; keeps a pointer
   // loop under the 65535 limit setting from running all the way to that limit.
   localparam int WALK_CAP    = 300;
   // Worst request: a walk of WALK_CAP fetches, plus the long response hold.
   localparam int STALL_LIMIT = 8000;
   localparam int HOLD_CYCLES = 150;
   localparam int HOT_COUNT   = 32;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_we      = 1'b0;
   logic [LIM_W-1:0] csr_wdata   = '0;
   int unsigned      fault_total;

   int unsigned sent_total   = 0;
   int unsigned rsp_total    = 0;
   int unsigned quiet_cycles = 0;
   int unsigned op_tally [4] = '{default: 0};
   logic        calm;

   // Stimulus-side view of the unit's storage. Only used to keep requests
   // legal: never read a memory word that was never written.
   logic [WORD_W-1:0] ac_shadow   [AC_COUNT];
   logic [WORD_W-1:0] word_shadow [MEM_WORDS];
   bit                word_known  [MEM_WORDS];
   logic [ADDR_W-1:0] known_addrs [$];
   logic [ADDR_W-1:0] hot_addrs   [HOT_COUNT];
   logic [LIM_W-1:0]  limit_shadow = LIMIT_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // no idling on either side for this stretch of requests
   assign calm = (sent_total >= 900) && (sent_total < 1150);

   indexed_indirect_ea_unit_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   indexed_indirect_ea_unit_core_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fault_total (fault_total)
   );

   // Response count and watchdog: any cycle with no handshake on either
   // channel counts toward the stall limit.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            rsp_total++;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Response side: ~16% random stalls, none in the calm stretch, and one
   // long hold-off while the sender keeps pushing, so the unit backs up.
   initial begin : rsp_side
      int unsigned hold_left = 0;
      bit          held      = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && sent_total >= 300) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 16);
         end
      end
   end

   function automatic logic [WORD_W-1:0] rand_word();
      return {4'($urandom), 32'($urandom)};
   endfunction

   // Indirect word: bit 22 indirect, bits 21:18 index, 17:0 offset, rest random.
   function automatic logic [WORD_W-1:0] ptr_word(input logic ind, input logic [IDX_W-1:0] idx,
                                                 input logic [ADDR_W-1:0] y);
      return {13'($urandom), ind, idx, y};
   endfunction

   function automatic req_type compose(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                       input logic [WORD_W-1:0] data, input logic ind,
                                       input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] y);
      req_type r;
      r.opcode    = op;
      r.address   = addr;
      r.data      = data;
      r.ind_bit   = ind;
      r.index_reg = idx;
      r.offset_y  = y;
      return r;
   endfunction

   // Pointer destinations: mostly the hot pool and accumulators so chains
   // keep going, plus written words, out-of-range and fully random offsets.
   function automatic logic [ADDR_W-1:0] pointer_target();
      case ($urandom_range(9))
         0, 1, 2, 3: return hot_addrs[$urandom_range(HOT_COUNT-1)];
         4, 5:       return ADDR_W'($urandom_range(AC_COUNT-1));
         6:          return known_addrs[$urandom_range(known_addrs.size()-1)];
         7:          return ADDR_W'($urandom_range(MEM_WORDS, (1 << ADDR_W) - 1));
         default:    return ADDR_W'($urandom);
      endcase
   endfunction

   // Follows a walk through the shadow; false if it would touch an unwritten
   // memory word or run past WALK_CAP fetches.
   function automatic bit walk_is_legal(input logic ind, input logic [IDX_W-1:0] idx,
                                        input logic [ADDR_W-1:0] y);
      int unsigned       hops;
      logic [WORD_W-1:0] w;
      hops = 0;
      while (1) begin
         if (idx != '0)
            y = y + ac_shadow[idx][ADDR_W-1:0];
         if (!ind || hops >= limit_shadow)
            return 1'b1;
         if (hops >= WALK_CAP)
            return 1'b0;
         hops++;
         if (y < AC_SPACE)
            w = ac_shadow[y[AC_AW-1:0]];
         else if (y >= MEM_END)
            return 1'b1;
         else if (!word_known[y[MEM_AW-1:0]])
            return 1'b0;
         else
            w = word_shadow[y[MEM_AW-1:0]];
         ind = w[IND_POS];
         idx = w[IDX_LSB +: IDX_W];
         y   = w[ADDR_W-1:0];
      end
      return 1'b0;
   endfunction

   // Random mix: writes build pointer chains in the hot pool, reads hit only
   // written words, accumulators or addresses past memory, and walks are
   // retried until legal, falling back to a direct address.
   function automatic req_type random_request();
      req_type           r;
      int unsigned       pick;
      logic              ind;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] y;
      bit                found;
      r = compose(OP_NONE, ADDR_W'($urandom), rand_word(), 1'($urandom), IDX_W'($urandom),
                  ADDR_W'($urandom));
      pick = $urandom_range(99);
      if (pick < 30) begin
         r.opcode = OP_WRITE;
         case ($urandom_range(9))
            0, 1:    r.address = ADDR_W'($urandom_range(AC_COUNT-1));
            2:       ; // anywhere in the 18-bit space
            default: r.address = hot_addrs[$urandom_range(HOT_COUNT-1)];
         endcase
         pick = $urandom_range(99);
         if (pick < 55)
            r.data = ptr_word(1'($urandom), ($urandom_range(99) < 60) ? '0 : IDX_W'($urandom),
                              pointer_target());
         else if (pick < 70)
            r.data = WORD_W'($urandom_range(40));
      end else if (pick < 55) begin
         r.opcode = OP_READ;
         case ($urandom_range(3))
            0:       r.address = ADDR_W'($urandom_range(AC_COUNT-1));
            3:       r.address = ADDR_W'($urandom_range(MEM_WORDS, (1 << ADDR_W) - 1));
            default: r.address = known_addrs[$urandom_range(known_addrs.size()-1)];
         endcase
      end else if (pick < 95) begin
         r.opcode  = OP_EA;
         r.ind_bit = 1'b0;
         found     = 1'b0;
         for (int t = 0; t < 8 && !found; t++) begin
            ind = ($urandom_range(99) < 70);
            idx = $urandom_range(1) ? '0 : IDX_W'($urandom);
            y   = pointer_target();
            if (walk_is_legal(ind, idx, y)) begin
               r.ind_bit   = ind;
               r.index_reg = idx;
               r.offset_y  = y;
               found       = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // Sends one request. Entered and left at a falling edge; valid holds
   // until the accept edge, then the next call either reloads or idles.
   task automatic issue(input req_type r);
      if (r.opcode == OP_WRITE) begin
         if (r.address < AC_SPACE) begin
            ac_shadow[r.address[AC_AW-1:0]] = r.data;
         end else if (r.address < MEM_END) begin
            if (!word_known[r.address[MEM_AW-1:0]])
               known_addrs.push_back(r.address);
            word_known[r.address[MEM_AW-1:0]]  = 1'b1;
            word_shadow[r.address[MEM_AW-1:0]] = r.data;
         end
      end
      op_tally[r.opcode]++;
      while (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_total++;
      @(negedge clock);
   endtask

   // Sender goes quiet until every response is back, then a short settle.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (rsp_total != sent_total) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Limit write; only called with the unit drained.
   task automatic set_limit(input logic [LIM_W-1:0] value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we       <= 1'b0;
      limit_shadow = value;
   endtask

   initial begin : stimulus
      logic [LIM_W-1:0] plan  [6];
      int unsigned      burst [6];
      foreach (ac_shadow[i]) ac_shadow[i] = '0;
      hot_addrs[0] = ADDR_W'(16);
      hot_addrs[1] = ADDR_W'(17);
      hot_addrs[2] = ADDR_W'(MEM_WORDS - 1);
      hot_addrs[3] = ADDR_W'(MEM_WORDS - 2);
      for (int i = 4; i < HOT_COUNT; i++)
         hot_addrs[i] = ADDR_W'($urandom_range(18, MEM_WORDS - 3));
      // limit settings per random phase: extremes, zero, two random ones and the reset value
      plan  = '{LIM_W'(1), '1, '0, LIM_W'($urandom_range(2, 64)),
                LIM_W'($urandom_range(100, WALK_CAP)), LIMIT_RESET};
      burst = '{280, 280, 120, 380, 360, 260};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, at the reset limit of 256.
      issue(compose(OP_WRITE, '0, '1, 1'b0, '0, '0));                         // AC0 all ones
      issue(compose(OP_READ, '0, '0, 1'b0, '0, '0));
      issue(compose(OP_WRITE, ADDR_W'(15), WORD_W'(18'h3FFFF), 1'b0, '0, '0)); // index that wraps
      issue(compose(OP_WRITE, ADDR_W'(16), ptr_word(1'b0, '0, 18'h00123), 1'b0, '0, '0));
      issue(compose(OP_WRITE, ADDR_W'(MEM_WORDS - 1), ptr_word(1'b1, '0, ADDR_W'(16)),
                    1'b0, '0, '0));
      issue(compose(OP_WRITE, ADDR_W'(17), ptr_word(1'b1, '0, ADDR_W'(17)),   // self loop
                    1'b0, '0, '0));
      issue(compose(OP_WRITE, ADDR_W'(1), ptr_word(1'b1, IDX_W'(15), 18'h00011),
                    1'b0, '0, '0));
      issue(compose(OP_WRITE, ADDR_W'(MEM_WORDS), '1, 1'b0, '0, '0));   // first word past memory
      issue(compose(OP_WRITE, '1, '1, 1'b1, '1, '1));                   // top address, all bits set
      issue(compose(OP_READ, ADDR_W'(MEM_WORDS - 1), '0, 1'b0, '0, '0));
      issue(compose(OP_READ, ADDR_W'(16), '0, 1'b0, '0, '0));
      issue(compose(OP_READ, ADDR_W'(15), '0, 1'b0, '0, '0));
      issue(compose(OP_READ, ADDR_W'(MEM_WORDS), '0, 1'b0, '0, '0));
      issue(compose(OP_READ, '1, '1, 1'b1, '1, '1));
      issue(compose(OP_EA, '0, '0, 1'b0, '0, '0));
      issue(compose(OP_EA, '0, '0, 1'b0, IDX_W'(15), '1));              // index add wraps
      issue(compose(OP_EA, '0, '0, 1'b1, '0, ADDR_W'(MEM_WORDS - 1)));  // two-level chain
      issue(compose(OP_EA, '0, '0, 1'b1, '0, ADDR_W'(5000)));           // fetch past memory
      issue(compose(OP_EA, '0, '0, 1'b1, '0, '1));
      issue(compose(OP_EA, '0, '0, 1'b1, '0, ADDR_W'(17)));             // loop hits the limit
      issue(compose(OP_EA, '0, '0, 1'b1, IDX_W'(15), 18'h3FFF0));       // wraps, then past memory
      issue(compose(OP_EA, '0, '0, 1'b1, '0, ADDR_W'(1)));              // via an accumulator word
      issue(compose(OP_NONE, '1, '1, 1'b1, '1, '1));                    // unused opcode
      drain_responses();

      for (int p = 0; p < 6; p++) begin
         set_limit(plan[p]);
         repeat (burst[p]) issue(random_request());
         drain_responses();
      end
      repeat (20) @(negedge clock);

      $display("Ran %0d requests: %0d writes, %0d reads, %0d address walks, %0d unused opcode",
               sent_total, op_tally[OP_WRITE], op_tally[OP_READ], op_tally[OP_EA],
               op_tally[OP_NONE]);
      $display("Indirection limits: reset, 1, 65535, 0, %0d, %0d; responses checked: %0d",
               plan[3], plan[4], rsp_total);
      if (fault_total == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
